### rtl/sps_pkg.sv
// Shared types and constants for the segmented prime sieve.
`default_nettype none
package sps_pkg;
  localparam int unsigned FieldWidth = 32;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic root_start;
    logic root_step;
    logic div_start;
    logic div_step;
    logic strike_init;
    logic strike_step;
    logic next_divisor;
    logic scan_read;
    logic scan_step;
  } sps_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic root_done;
    logic divisor_over;
    logic div_done;
    logic skip;
    logic strike_last;
    logic scan_hit;
    logic scan_last;
  } sps_sts_t;
endpackage
`default_nettype wire

### rtl/segmented_prime_sieve.sv
// Top level of the segmented prime sieve.
// One request sieves the odd integers of a SEGMENT_SIZE-aligned segment and returns its primes
// in ascending order, the last flagged; an empty segment returns one result with segment_empty.
// One request is worked at a time. A segment first clears the flag memory, then computes the
// square root of its end, then per odd divisor up to that root takes the remainder in the
// bit-serial remainder divider and strikes the divisor's odd multiples, then scans the flags,
// stretched by any output stall; the divider dominates the time a high 32-bit segment takes.
`default_nettype none
module segmented_prime_sieve #(
  parameter int unsigned SEGMENT_SIZE = 128,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] segment_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      prime_value_o,
  output logic             last_of_segment_o,
  output logic             segment_empty_o
);
  import sps_pkg::*;

  sps_cmd_t cmd;
  sps_sts_t sts;
  logic [FieldWidth-1:0] value;

  sps_datapath #(.SEGMENT_SIZE(SEGMENT_SIZE), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .segment_start_i, .cmd_i(cmd), .sts_o(sts), .value_o(value)
  );

  sps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .value_i(value), .cmd_o(cmd),
    .out_valid_o, .out_stall_i, .prime_value_o, .last_of_segment_o, .segment_empty_o
  );
endmodule
`default_nettype wire

### rtl/sps_datapath.sv
// Sieve datapath: square root, remainder divider, strike unit, flag memory, scan.
`default_nettype none
module sps_datapath #(
  parameter int unsigned SEGMENT_SIZE = 128,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [sps_pkg::FieldWidth-1:0] segment_start_i,
  input  wire sps_pkg::sps_cmd_t              cmd_i,
  output sps_pkg::sps_sts_t                   sts_o,
  output logic [sps_pkg::FieldWidth-1:0]      value_o
);
  import sps_pkg::*;

  localparam int unsigned Depth = SEGMENT_SIZE / 2;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned SW = $clog2(SEGMENT_SIZE);
  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned W1 = VALUE_WIDTH + 1;
  localparam int unsigned RW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned RS = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned RSW = 2 * RS;
  localparam int unsigned RCW = $clog2(RS + 1);
  localparam int unsigned DCW = $clog2(W + 1);
  localparam logic [W-1:0] VMax = '1;

  logic [W-1:0] start_q, end_q, first_q;
  logic [CW-1:0] count_q;
  logic flags_q [Depth];
  logic flag_rd_q;

  // integer square root, one result bit per step
  logic [W1:0] rrem_q, rrem_d;
  logic [RW-1:0] root_q, root_d;
  logic [RCW-1:0] rcnt_q;
  logic [RSW-1:0] rsrc_q;
  logic [RW+1:0] trial;
  logic [W1:0] rshift;

  // restoring divider: start mod divisor
  logic [RW-1:0] div_q;
  logic [W-1:0] dquo_q;
  logic [RW:0] drem_q;
  logic [DCW-1:0] dcnt_q;
  logic [RW:0] dtry;

  logic [W1-1:0] j_q, j_next;
  logic [W1-1:0] endx, startx, ix, i2x, sq, remx, gap, jc;
  logic [AW-1:0] widx;
  logic skip_d;
  logic [W1-1:0] jset_d;

  logic [AW-1:0] sidx_q;
  logic [W-1:0] seg_in, seg_aln, seg_end;

  assign seg_in = W'(segment_start_i);
  assign seg_aln = {seg_in[W-1:SW], {SW{1'b0}}};
  assign seg_end = (seg_aln > VMax - W'(SEGMENT_SIZE - 1)) ? VMax
                 : seg_aln + W'(SEGMENT_SIZE - 1);

  assign endx = W1'(end_q);
  assign startx = W1'(start_q);
  assign ix = W1'(div_q);
  assign i2x = {ix[W1-2:0], 1'b0};
  assign remx = W1'(drem_q);

  always_comb begin
    trial = {root_q, 2'b01};
    rshift = {rrem_q[W1-2:0], 2'b00} | (W1+1)'(rsrc_q[RSW-1:RSW-2]);
    rrem_d = rshift;
    root_d = {root_q[RW-2:0], 1'b0};
    if (rshift >= (W1+1)'(trial)) begin
      rrem_d = rshift - (W1+1)'(trial);
      root_d = {root_q[RW-2:0], 1'b1};
    end
  end

  assign dtry = {drem_q[RW-1:0], dquo_q[W-1]};

  always_comb begin
    sq = W1'(div_q) * W1'(div_q);
    skip_d = 1'b0;
    jc = startx;
    if (remx != '0) begin
      gap = ix - remx;
      if (startx > endx - gap || gap > endx - startx) skip_d = 1'b1;
      jc = startx + gap;
    end else begin
      gap = '0;
    end
    if (jc < sq) jc = sq;
    if (!jc[0]) begin
      if (jc > endx || endx - jc < ix) skip_d = 1'b1;
      jc = jc + ix;
    end
    jset_d = jc;
  end

  assign j_next = j_q + i2x;
  assign widx = AW'((j_q - W1'(first_q)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
      dcnt_q <= '0;
      sidx_q <= '0;
    end else begin
      if (cmd_i.load) sidx_q <= '0;
      else if (cmd_i.clear_step || cmd_i.scan_step) sidx_q <= sidx_q + 1'b1;
      if (cmd_i.root_start) rcnt_q <= RCW'(RS);
      else if (cmd_i.root_step) rcnt_q <= rcnt_q - 1'b1;
      if (cmd_i.div_start) dcnt_q <= DCW'(W);
      else if (cmd_i.div_step) dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= seg_aln;
      end_q <= seg_end;
      first_q <= seg_aln | W'(1);
      if ((seg_aln | W'(1)) > seg_end) count_q <= '0;
      else if (((seg_end - (seg_aln | W'(1))) >> 1) < W'(Depth - 1))
        count_q <= CW'(((seg_end - (seg_aln | W'(1))) >> 1) + 1'b1);
      else count_q <= CW'(Depth);
      div_q <= RW'(3);
    end
    if (cmd_i.root_start) begin
      rsrc_q <= RSW'(end_q);
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rsrc_q <= {rsrc_q[RSW-3:0], 2'b00};
      rrem_q <= rrem_d;
      root_q <= root_d;
    end
    if (cmd_i.div_start) begin
      dquo_q <= start_q;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      dquo_q <= {dquo_q[W-2:0], 1'b0};
      drem_q <= (dtry >= (RW+1)'(div_q)) ? dtry - (RW+1)'(div_q) : dtry;
    end
    if (cmd_i.strike_init) j_q <= jset_d;
    else if (cmd_i.strike_step) j_q <= j_next;
    if (cmd_i.next_divisor) div_q <= div_q + RW'(2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) flags_q[sidx_q] <= 1'b1;
    else if (cmd_i.strike_step) flags_q[widx] <= 1'b0;
    if (cmd_i.scan_read) flag_rd_q <= flags_q[sidx_q];
  end

  logic [W-1:0] sval;
  assign sval = first_q + W'({sidx_q, 1'b0});
  assign value_o = (sval == W'(1)) ? sps_pkg::FieldWidth'(2) : sps_pkg::FieldWidth'(sval);

  logic [CW-1:0] sidx_x;
  assign sidx_x = CW'(sidx_q);

  assign sts_o.clear_last = (sidx_q == AW'(Depth - 1));
  assign sts_o.root_done = (rcnt_q == '0);
  assign sts_o.divisor_over = (RW+1)'(div_q) > (RW+1)'(root_q);
  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.skip = skip_d;
  assign sts_o.strike_last = (endx - j_q < i2x);
  assign sts_o.scan_hit = (sidx_x < count_q) && flag_rd_q;
  assign sts_o.scan_last = (sidx_x + 1'b1 >= count_q);
endmodule
`default_nettype wire

### rtl/sps_ctrl.sv
// Sieve sequencer: clear, root, per-divisor remainder and strike loop, then scan with output buffer.
`default_nettype none
module sps_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire sps_pkg::sps_sts_t              sts_i,
  input  wire logic [sps_pkg::FieldWidth-1:0] value_i,
  output sps_pkg::sps_cmd_t                   cmd_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [sps_pkg::FieldWidth-1:0]      prime_value_o,
  output logic                                last_of_segment_o,
  output logic                                segment_empty_o
);
  import sps_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLEAR  = 10'b0000000010,
    S_ROOT   = 10'b0000000100,
    S_CHECK  = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_PLACE  = 10'b0000100000,
    S_STRIKE = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_SCAN   = 10'b0100000000,
    S_FLUSH  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic found_q, found_d;
  logic [FieldWidth-1:0] hold_q;
  logic obuf_ready, emit, emit_empty, emit_last, hold_load;

  assign obuf_ready = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    found_d = found_q;
    emit = 1'b0;
    emit_empty = 1'b0;
    emit_last = 1'b0;
    hold_load = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_start = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.root_done) cmd_o.root_step = 1'b1;
        else if (sts_i.divisor_over) begin
          found_d = 1'b0;
          state_d = S_READ;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_PLACE;
      else cmd_o.div_step = 1'b1;
      S_PLACE: begin
        if (sts_i.skip) begin
          cmd_o.next_divisor = 1'b1;
          state_d = S_CHECK;
        end else begin
          cmd_o.strike_init = 1'b1;
          state_d = S_STRIKE;
        end
      end
      S_STRIKE: begin
        cmd_o.strike_step = 1'b1;
        if (sts_i.strike_last) begin
          cmd_o.next_divisor = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_READ: begin
        cmd_o.scan_read = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: if (obuf_ready || !(sts_i.scan_hit && found_q)) begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          emit = found_q;
          hold_load = 1'b1;
          found_d = 1'b1;
        end
        state_d = sts_i.scan_last ? S_FLUSH : S_READ;
      end
      S_FLUSH: if (obuf_ready) begin
        emit = 1'b1;
        emit_empty = !found_q;
        emit_last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (emit) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) hold_q <= value_i;
    if (emit) begin
      prime_value_o <= emit_empty ? '0 : hold_q;
      segment_empty_o <= emit_empty;
      last_of_segment_o <= emit_last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (state_q == S_SCAN || state_q == S_FLUSH)) else $error("emit outside scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(prime_value_o)) else $error("stalled result changed");
endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for segmented_prime_sieve: directed and random segments checked against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        empty;
  } prime_rec_t;

  typedef struct {
    logic [31:0] start;
    bit          typed;
    int          count;
    logic [31:0] first;
  } seg_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] segment_start_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] prime_value_o;
  logic        last_of_segment_o;
  logic        segment_empty_o;

  prime_rec_t  pending_primes[$];
  int          fail_count = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  segmented_prime_sieve u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .segment_start_i,
    .out_valid_o, .out_stall_i, .prime_value_o, .last_of_segment_o, .segment_empty_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #400_000_000;
    $display("segmented_prime_sieve regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic void sieve_segment(input logic [31:0] seg_in, ref prime_rec_t res[$]);
    longint unsigned start, stop, first_odd, cnt, root, i, rem, j, v;
    bit flags[64];
    prime_rec_t r;
    start = seg_in - (seg_in % 128);
    stop = start + 127;
    first_odd = start | 1;
    cnt = (stop - first_odd) / 2 + 1;
    if (cnt > 64) cnt = 64;
    res.delete();
    for (int k = 0; k < 64; k++) flags[k] = (k < cnt);
    root = longint'($sqrt(real'(stop)));
    while (root * root > stop) root--;
    while ((root + 1) * (root + 1) <= stop) root++;
    for (i = 3; i <= root; i += 2) begin
      rem = start % i;
      j = (rem == 0) ? start : start + (i - rem);
      if (j < i * i) j = i * i;
      if (j[0] == 1'b0) j += i;
      while (j <= stop) begin
        flags[(j - first_odd) / 2] = 1'b0;
        j += 2 * i;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      if (flags[k]) begin
        v = first_odd + 2 * k;
        if (v == 1) v = 2;
        r.value = v[31:0];
        r.last = 1'b0;
        r.empty = 1'b0;
        res.insert(res.size(), r);
      end
    end
    if (res.size() == 0) begin
      r.value = '0;
      r.last = 1'b1;
      r.empty = 1'b1;
      res.insert(res.size(), r);
    end else begin
      res[res.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_segment(input logic [31:0] start, input bit typed, input int count,
                              input logic [31:0] first);
    prime_rec_t res[$];
    sieve_segment(start, res);
    if (typed && (res.size() != count || res[0].value != first))
      report_mismatch($sformatf("segment %h: predictor gives %0d results first %0d",
                                start, res.size(), res[0].value));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    segment_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    foreach (res[k]) pending_primes.insert(pending_primes.size(), res[k]);
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    prime_rec_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_primes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", prime_value_o));
      end else begin
        e = pending_primes.pop_front();
        if (prime_value_o !== e.value)
          report_mismatch($sformatf("prime_value %0d, want %0d", prime_value_o, e.value));
        if (last_of_segment_o !== e.last)
          report_mismatch($sformatf("last_of_segment %b, want %b for %0d",
                                    last_of_segment_o, e.last, e.value));
        if (segment_empty_o !== e.empty)
          report_mismatch($sformatf("segment_empty %b, want %b for %0d",
                                    segment_empty_o, e.empty, e.value));
      end
    end
  end

  initial begin
    seg_row_t rows[11];
    logic [31:0] s;
    int big_left;
    rows = '{
      '{32'h0000_0000, 1'b1, 31, 32'd2},
      '{32'h0000_007F, 1'b1, 31, 32'd2},
      '{32'h0000_0080, 1'b0, 0, 0},
      '{32'h0000_00FF, 1'b0, 0, 0},
      '{32'h0000_0100, 1'b0, 0, 0},
      '{32'd2010752,   1'b1, 1, 32'd0},
      '{32'd2010829,   1'b1, 1, 32'd0},
      '{32'h0001_0000, 1'b0, 0, 0},
      '{32'h0000_FF80, 1'b0, 0, 0},
      '{32'h0005_5555, 1'b0, 0, 0},
      '{32'hFFFF_FFFF, 1'b0, 0, 0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) send_segment(rows[k].start, rows[k].typed, rows[k].count, rows[k].first);
    in_valid_i <= 1'b0;
    // hold off until the block has drained
    while (pending_primes.size() != 0) @(posedge clk_i);
    big_left = 2;
    for (int n = 0; n < 100; n++) begin
      if (n >= 80) quiet = 1'b1;
      if (big_left > 0 && $urandom_range(0, 39) == 0) begin
        s = $urandom;
        big_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        s = $urandom_range(0, 32'h000F_FFFF);
      end else begin
        s = $urandom_range(0, 32'h0000_FFFF);
      end
      send_segment(s, 1'b0, 0, 0);
    end
    in_valid_i <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("segmented_prime_sieve regression: pass");
    end else begin
      $display("segmented_prime_sieve regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
